FILE: sv/clr_pkg.sv
// Shared constants, codes and types for the colormap lookup block.
`default_nettype none

package clr_pkg;

    localparam int NUM_MAPS    = 4;
    localparam int MAP_ENTRIES = 256;
    localparam int MEM_DEPTH   = NUM_MAPS * MAP_ENTRIES;
    localparam int ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int ENT_W       = $clog2(MAP_ENTRIES);
    localparam int COLOR_W     = 24;
    localparam int CFG_W       = 3;
    localparam int MAP_W       = 2;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_APPLY  = 2'd1;
    localparam logic [1:0] MODE_REVERT = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_LOADED = 2'd1;
    localparam logic [1:0] ST_NO_MATCH   = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_SCAN,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [COLOR_W-1:0]  wdata;
        logic [ADDR_W-1:0]   raddr;
    } mem_req_t;

    function automatic logic [ADDR_W-1:0] map_addr(input logic [MAP_W-1:0] map,
                                                   input logic [ENT_W-1:0] entry);
        return ADDR_W'(32'(map) * 32'(MAP_ENTRIES) + 32'(entry));
    endfunction

endpackage

`default_nettype wire

FILE: sv/clr_table.sv
// Color table memory with one write port and one registered read port.
`default_nettype none

module clr_table
    import clr_pkg::*;
(
    input  wire logic               aclk,
    input  wire mem_req_t           mem_req,
    output logic [COLOR_W-1:0]      rd_data
);

    logic [COLOR_W-1:0] mem [MEM_DEPTH];

    always_ff @(posedge aclk) begin
        if (mem_req.we) begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        rd_data <= mem[mem_req.raddr];
    end

endmodule

`default_nettype wire

FILE: sv/clr_ctrl.sv
// Item sequencer: table writes, apply lookups, revert scans and the output register.
`default_nettype none

module clr_ctrl
    import clr_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wen,
    input  wire logic [CFG_W-1:0]   cfg_wdata,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [31:0]        s_tdata,
    input  wire logic [3:0]         s_tuser,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [31:0]             m_tdata,
    output logic [1:0]              m_tuser,
    output mem_req_t                mem_req,
    input  wire logic [COLOR_W-1:0] rd_data
);

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   maps_loaded_reg;
    logic [MAP_W-1:0]   map_reg;
    logic [COLOR_W-1:0] want_reg;
    logic [ENT_W-1:0]   idx_reg;
    logic [31:0]        res_data_reg;
    logic [1:0]         res_status_reg;
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    logic [1:0]         in_mode;
    logic [MAP_W-1:0]   in_map;
    logic [7:0]         in_entry;
    logic [7:0]         in_c0;
    logic [7:0]         in_c1;
    logic [7:0]         in_c2;
    logic               accept;
    logic               loaded;
    logic               c0_in_range;
    logic               write_ok;
    logic               out_free;
    logic               out_load;
    logic               scan_hit;
    logic               scan_last;

    assign in_mode  = s_tuser[1:0];
    assign in_map   = s_tuser[3:2];
    assign in_entry = s_tdata[7:0];
    assign in_c0    = s_tdata[15:8];
    assign in_c1    = s_tdata[23:16];
    assign in_c2    = s_tdata[31:24];

    assign accept      = s_tvalid && s_tready;
    assign loaded      = (32'(in_map) < 32'(maps_loaded_reg)) && (32'(in_map) < 32'(NUM_MAPS));
    assign c0_in_range = 32'(in_c0) < 32'(MAP_ENTRIES);
    assign write_ok    = (32'(in_map) < 32'(NUM_MAPS)) && (32'(in_entry) < 32'(MAP_ENTRIES));
    assign out_free    = !m_tvalid_reg || m_tready;
    assign scan_hit    = rd_data == want_reg;
    assign scan_last   = idx_reg == ENT_W'(MAP_ENTRIES - 1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    priority case (in_mode)
                        MODE_APPLY:  state_next = (loaded && c0_in_range) ? S_APPLY : S_EMIT;
                        MODE_REVERT: state_next = loaded ? S_SCAN : S_EMIT;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_APPLY: state_next = S_EMIT;
            S_SCAN: begin
                if (scan_hit || scan_last) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = state_reg == S_IDLE;
        out_load      = (state_reg == S_EMIT) && out_free;
        mem_req.we    = accept && (in_mode == MODE_WRITE) && write_ok;
        mem_req.waddr = map_addr(in_map, ENT_W'(in_entry));
        mem_req.wdata = {in_c2, in_c1, in_c0};
        unique case (state_reg)
            S_IDLE: begin
                if (in_mode == MODE_REVERT) begin
                    mem_req.raddr = map_addr(in_map, '0);
                end else begin
                    mem_req.raddr = map_addr(in_map, ENT_W'(in_c0));
                end
            end
            S_SCAN:  mem_req.raddr = map_addr(map_reg, idx_reg + ENT_W'(1));
            default: mem_req.raddr = map_addr(map_reg, idx_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            maps_loaded_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wen) begin
                maps_loaded_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    map_reg        <= in_map;
                    want_reg       <= {in_c0, in_c1, in_c2};
                    idx_reg        <= '0;
                    res_status_reg <= ST_NOT_LOADED;
                    if (in_mode == MODE_APPLY) begin
                        res_data_reg <= {8'd0, in_c2, in_c1, in_c0};
                    end else begin
                        res_data_reg <= '0;
                    end
                end
            end
            S_APPLY: begin
                res_data_reg   <= {8'd0, rd_data[7:0], rd_data[15:8], rd_data[23:16]};
                res_status_reg <= ST_OK;
            end
            S_SCAN: begin
                if (scan_hit) begin
                    res_data_reg   <= {8'(idx_reg), 24'd0};
                    res_status_reg <= ST_OK;
                end else if (scan_last) begin
                    res_data_reg   <= '0;
                    res_status_reg <= ST_NO_MATCH;
                end else begin
                    idx_reg <= idx_reg + ENT_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            m_tdata_reg <= res_data_reg;
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

FILE: sv/colormap_lookup_and_reverse.sv
// Colormap lookup and reverse lookup: top level.
// A write beat leaves the sequencer in S_IDLE, so the next beat can follow at once.
// An apply beat goes through S_APPLY, where the table entry read is captured, and S_EMIT into
// m_tdata; a pass-through beat goes straight to S_EMIT. A revert beat scans the map one table
// read per cycle until a match or the last entry, then goes to S_EMIT; an unloaded map goes
// straight to S_EMIT. s_tready returns high in the cycle after the result is loaded into m_tdata.
// Reset clears the sequencer, the output valid flag and maps_loaded; table contents stay undefined.
`default_nettype none

module colormap_lookup_and_reverse
    import clr_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wen,
    input  wire logic [CFG_W-1:0] cfg_wdata,   // maps_loaded
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [31:0]      s_tdata,     // entry_index, chan0, chan1, chan2
    input  wire logic [3:0]       s_tuser,     // mode, map_select
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [31:0]           m_tdata,     // out_chan0, out_chan1, out_chan2, color_index
    output logic [1:0]            m_tuser      // status
);

    mem_req_t           mem_req;
    logic [COLOR_W-1:0] rd_data;

    clr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    clr_table u_table (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

FILE: sv/clr_check.sv
// Port-level assertions for the colormap block and their binding to the top level.
`default_nettype none

module clr_check
    import clr_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic [3:0]       s_tuser,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [31:0]      m_tdata,
    input wire logic [1:0]       m_tuser
);

    // After an apply or revert beat is accepted, the input is not ready in the next cycle.
    a_busy_after_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[1:0] == MODE_APPLY || s_tuser[1:0] == MODE_REVERT))
        |=> !s_tready)
        else $error("input taken right after an apply or revert beat");

    // A write beat never blocks the next one.
    a_write_keeps_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[1:0] == MODE_WRITE) |=> s_tready)
        else $error("write beat stalled the input");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result beat changed while stalled");

    // A miss carries index zero and no channel data.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_NO_MATCH) |-> (m_tdata == 32'd0))
        else $error("miss result with nonzero payload");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_NOT_LOADED || m_tuser == ST_NO_MATCH))
        else $error("unknown status code on result beat");

endmodule

bind colormap_lookup_and_reverse clr_check u_clr_check (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

`default_nettype wire
